// ===== rtl/a85enc_pkg.sv =====
// Shared types and constants for the line-wrapping Ascii85 encoder.
`timescale 1ns / 1ps
`default_nettype none
package a85enc_pkg;

  localparam int unsigned NumDigits  = 5;
  localparam int unsigned DigitBase  = 85;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned QuotW      = 64 - RecipShift;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] Recip      = 32'd3233857729;
  localparam logic [7:0]  CharZero   = 8'h21;
  localparam logic [7:0]  CharZ      = 8'h7a;
  localparam logic [7:0]  CharNl     = 8'h0a;
  localparam logic [7:0]  CharTilde  = 8'h7e;
  localparam logic [7:0]  CharGt     = 8'h3e;
  localparam logic [7:0]  WidthReset = 8'd64;
  localparam logic [7:0]  WidthMin   = 8'd8;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  ndig;
    logic        zero;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [NumDigits-1:0][7:0] digs;
    logic [2:0]                ndig;
    logic                      zero;
    logic                      last;
  } bundle_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_NEWLINE,
    ST_TERM_NL,
    ST_TILDE,
    ST_CLOSE
  } emit_state_e;

endpackage
`default_nettype wire

// ===== rtl/ascii85_encoder_line_wrap_unit.sv =====
// Top level of the line-wrapping Ascii85 encoder.
// The request that completes a group passes the job queue, the five-step reciprocal-multiplier
// conversion and the sequencer before its first character reaches the output register.
// Throughput: one character per cycle at the output register within a group while out_ready_i
// is high. The front end keeps taking bytes while a group converts, until the job queue is full.
// Reset clears all control state and the group; the line width returns to 64.
`timescale 1ns / 1ps
`default_nettype none
module ascii85_encoder_line_wrap_unit
  import a85enc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            end_of_run_o
);

  logic [7:0] width_q, width_eff;
  job_t       front_job, queue_job;
  bundle_t    bundle;
  logic       front_valid, front_ready;
  logic       queue_valid, queue_ready;
  logic       bundle_valid, bundle_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  assign width_eff = (width_q < WidthMin) ? WidthMin : width_q;

  a85enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  a85enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_job)
  );

  a85enc_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (queue_valid),
    .job_ready_o    (queue_ready),
    .job_i          (queue_job),
    .bundle_valid_o (bundle_valid),
    .bundle_ready_i (bundle_ready),
    .bundle_o       (bundle)
  );

  a85enc_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width_eff),
    .bundle_valid_i (bundle_valid),
    .bundle_ready_o (bundle_ready),
    .bundle_i       (bundle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule
`default_nettype wire

// ===== rtl/a85enc_front.sv =====
// Front end: gathers bytes into groups and turns each request that completes a group or ends the stream into a job.
`timescale 1ns / 1ps
`default_nettype none
module a85enc_front
  import a85enc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  output logic            job_valid_o,
  input  wire logic       job_ready_i,
  output job_t            job_o
);

  logic [23:0] group_q, group_d;
  logic [1:0]  count_q, count_d;
  logic        accept;
  logic        full_group;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign full_group  = (count_q == 2'd3);
  assign job_valid_o = in_valid_i && (full_group || is_last_i);

  always_comb begin
    job_o = '0;
    unique case (count_q)
      2'd0: job_o.word = {data_byte_i, 24'd0};
      2'd1: job_o.word = {group_q[7:0], data_byte_i, 16'd0};
      2'd2: job_o.word = {group_q[15:0], data_byte_i, 8'd0};
      2'd3: job_o.word = {group_q, data_byte_i};
      default: job_o.word = '0;
    endcase
    job_o.zero = full_group && (job_o.word == 32'd0);
    job_o.last = is_last_i;
    if (full_group) begin
      job_o.ndig = job_o.zero ? 3'd1 : 3'd5;
    end else begin
      job_o.ndig = 3'({1'b0, count_q} + 3'd2);
    end
  end

  always_comb begin
    group_d = group_q;
    count_d = count_q;
    if (accept) begin
      if (full_group || is_last_i) begin
        group_d = '0;
        count_d = '0;
      end else begin
        group_d = {group_q[15:0], data_byte_i};
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      count_q <= '0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/a85enc_fifo.sv =====
// Short job queue between the front end and the conversion unit.
`timescale 1ns / 1ps
`default_nettype none
module a85enc_fifo
  import a85enc_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("Queue occupancy exceeds its depth.");

endmodule
`default_nettype wire

// ===== rtl/a85enc_conv.sv =====
// Base-85 conversion unit: one digit per cycle by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none
module a85enc_conv
  import a85enc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      bundle_valid_o,
  input  wire logic bundle_ready_i,
  output bundle_t   bundle_o
);

  logic                      busy_q, done_q;
  logic [2:0]                step_q;
  logic [31:0]               cur_q;
  logic [NumDigits-1:0][7:0] digs_q;
  logic [2:0]                ndig_q;
  logic                      zero_q, last_q;

  logic [63:0]      prod;
  logic [QuotW-1:0] quot;
  logic [13:0]      qmul;
  logic [6:0]       rem;
  logic [7:0]       digit;
  logic             load, take, finish;

  assign prod   = 64'(cur_q) * 64'(Recip);
  assign quot   = prod[63:RecipShift];
  assign qmul   = 14'(quot[6:0]) * 14'(DigitBase);
  assign rem    = cur_q[6:0] - qmul[6:0];
  assign digit  = {1'b0, rem} + CharZero;

  assign take        = done_q && bundle_ready_i;
  assign job_ready_o = !busy_q && (!done_q || bundle_ready_i);
  assign load        = job_valid_i && job_ready_o;
  assign finish      = busy_q && (step_q == 3'(NumDigits - 1));

  assign bundle_valid_o = done_q;
  assign bundle_o.digs  = digs_q;
  assign bundle_o.ndig  = ndig_q;
  assign bundle_o.zero  = zero_q;
  assign bundle_o.last  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (finish) begin
          busy_q <= 1'b0;
        end
      end
      if (finish) begin
        done_q <= 1'b1;
      end else if (take) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= job_i.word;
      ndig_q <= job_i.ndig;
      zero_q <= job_i.zero;
      last_q <= job_i.last;
    end else if (busy_q) begin
      cur_q     <= 32'(quot);
      digs_q[0] <= digit;
      for (int j = 1; j < NumDigits; j++) begin
        digs_q[j] <= digs_q[j-1];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(busy_q && done_q))
    else $error("Conversion unit is busy while holding a finished result.");

endmodule
`default_nettype wire

// ===== rtl/a85enc_emit.sv =====
// Back end: character sequencer with column tracking and an output register.
`timescale 1ns / 1ps
`default_nettype none
module a85enc_emit
  import a85enc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] width_i,
  input  wire logic       bundle_valid_i,
  output logic            bundle_ready_o,
  input  wire bundle_t    bundle_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            end_of_run_o
);

  emit_state_e state_q, state_d;

  logic [NumDigits-1:0][7:0] digs_q;
  logic [2:0]                ndig_q, idx_q, idx_d;
  logic                      zero_q, last_q;
  logic [7:0]                col_q, col_d;
  logic                      out_valid_q, out_end_q;
  logic [7:0]                out_char_q;

  logic [7:0] col_inc, limit, ch;
  logic       wrap, more_dig, more_nl, term_nl, eor;
  logic       out_free, fire, load;

  assign out_free       = !out_valid_q || out_ready_i;
  assign fire           = (state_q != ST_IDLE) && out_free;
  assign bundle_ready_o = (state_q == ST_IDLE);
  assign load           = bundle_valid_i && bundle_ready_o;

  assign col_inc  = col_q + 8'd1;
  assign limit    = zero_q ? (width_i - 8'd1) : width_i;
  assign wrap     = (col_inc >= limit);
  assign more_dig = ((idx_q + 3'd1) < ndig_q);
  assign more_nl  = (idx_q < ndig_q);
  assign term_nl  = (col_inc > (width_i - 8'd2));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (fire) begin
          if (wrap) begin
            state_d = ST_NEWLINE;
          end else if (more_dig) begin
            state_d = ST_DIGIT;
          end else if (last_q) begin
            state_d = term_nl ? ST_TERM_NL : ST_TILDE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NEWLINE: begin
        if (fire) begin
          if (more_nl) begin
            state_d = ST_DIGIT;
          end else if (last_q) begin
            state_d = ST_TILDE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TERM_NL: begin
        if (fire) begin
          state_d = ST_TILDE;
        end
      end
      ST_TILDE: begin
        if (fire) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ch    = CharNl;
    eor   = 1'b0;
    col_d = col_q;
    idx_d = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_DIGIT: begin
        ch    = zero_q ? CharZ : digs_q[idx_q];
        eor   = !wrap && !more_dig && !last_q;
        col_d = col_inc;
        idx_d = idx_q + 3'd1;
      end
      ST_NEWLINE: begin
        eor   = !more_nl && !last_q;
        col_d = '0;
      end
      ST_TERM_NL: begin
        ch = CharNl;
      end
      ST_TILDE: begin
        ch = CharTilde;
      end
      ST_CLOSE: begin
        ch    = CharGt;
        eor   = 1'b1;
        col_d = '0;
      end
      default: begin
        ch = CharNl;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load || fire) begin
        state_q <= state_d;
        idx_q   <= idx_d;
        col_q   <= col_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digs_q <= bundle_i.digs;
      ndig_q <= bundle_i.ndig;
      zero_q <= bundle_i.zero;
      last_q <= bundle_i.last;
    end
    if (fire) begin
      out_char_q <= ch;
      out_end_q  <= eor;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign end_of_run_o = out_end_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fire && state_q == ST_TILDE) |=> (state_q == ST_CLOSE))
    else $error("Terminator opening is not followed by its closing character.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fire && state_q == ST_CLOSE) |=>
      (out_valid_q && out_end_q && out_char_q == CharGt && col_q == 8'd0))
    else $error("Stream end did not close the run and clear the column.");

endmodule
`default_nettype wire

// ===== verif/a85_stream_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the Ascii85 character stream and compares it with the encoder output.
module a85_stream_checker
  import a85enc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic       end_of_run_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
  } enc_char_t;

  enc_char_t   pending_chars[$];
  enc_char_t   step_chars[$];
  logic [7:0]  width_q;
  logic [23:0] group_q;
  logic [1:0]  count_q;
  logic [7:0]  column_q;
  int          fails;

  function automatic int unsigned line_limit();
    return (width_q < WidthMin) ? int'(WidthMin) : int'(width_q);
  endfunction

  task automatic put_char(input logic [7:0] c);
    step_chars.push_back('{ch: c, eor: 1'b0});
  endtask

  task automatic put_digits(input logic [31:0] word, input int unsigned ndig);
    logic [7:0]  digs[5];
    int unsigned rest;
    int unsigned lim;
    lim  = line_limit();
    rest = word;
    for (int j = 4; j >= 0; j--) begin
      digs[j] = 8'(rest % DigitBase) + CharZero;
      rest    = rest / DigitBase;
    end
    for (int j = 0; j < ndig; j++) begin
      put_char(digs[j]);
      column_q = column_q + 8'd1;
      if (column_q >= lim) begin
        put_char(CharNl);
        column_q = '0;
      end
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [31:0] word;
    int unsigned lim;
    int unsigned k;
    enc_char_t   tail;
    lim = line_limit();
    step_chars.delete();
    if (count_q == 2'd3) begin
      word    = {group_q, b};
      group_q = '0;
      count_q = '0;
      if (word == '0) begin
        put_char(CharZ);
        column_q = column_q + 8'd1;
        if (column_q >= lim - 1) begin
          put_char(CharNl);
          column_q = '0;
        end
      end else begin
        put_digits(word, NumDigits);
      end
    end else begin
      group_q = {group_q[15:0], b};
      count_q = count_q + 2'd1;
      if (last) begin
        k    = count_q;
        word = {8'h00, group_q};
        word = word << (8 * (4 - k));
        put_digits(word, k + 1);
      end
    end
    if (last) begin
      if (column_q > lim - 2) put_char(CharNl);
      put_char(CharTilde);
      put_char(CharGt);
      group_q  = '0;
      count_q  = '0;
      column_q = '0;
    end
    if (step_chars.size() > 0) begin
      tail     = step_chars.pop_back();
      tail.eor = 1'b1;
      step_chars.push_back(tail);
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    enc_char_t want;
    if (!rst_ni) begin
      width_q  = WidthReset;
      group_q  = '0;
      count_q  = '0;
      column_q = '0;
      fails    = 0;
      pending_chars.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected result: out_char %h end_of_run %b", out_char_i, end_of_run_i);
          fails++;
        end else begin
          want = pending_chars.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char_i);
            fails++;
          end
          if (end_of_run_i !== want.eor) begin
            $error("end_of_run: expected %b, actual %b", want.eor, end_of_run_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) width_q = cfg_data_i;
      if (in_valid_i && in_ready_i) encode_byte(data_byte_i, is_last_i);
    end
    fail_count_o <= fails;
    pending_o    <= pending_chars.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top that drives byte streams and line widths into the Ascii85 encoder.
module tb;
  import a85enc_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       end_of_run;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  logic       no_idle;

  ascii85_encoder_line_wrap_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (data_byte),
    .is_last_i   (is_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .end_of_run_o(end_of_run)
  );

  a85_stream_checker stream_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .data_byte_i (data_byte),
    .is_last_i   (is_last),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_char_i  (out_char),
    .end_of_run_i(end_of_run),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_stream(input int len);
    int         mode;
    logic [7:0] b;
    mode = 0;
    for (int i = 0; i < len; i++) begin
      if (i % 4 == 0) mode = $urandom_range(0, 7);
      case (mode)
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_width(input logic [7:0] w);
    cfg_data <= w;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : out_side
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int         phase_items;
    int         len;
    logic [7:0] w;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    is_last     = 1'b0;
    no_idle     = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default width: zero group, full-scale group, partial groups of one to three bytes,
    // and a zero group that ends the stream.
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b0);
    send_byte(8'hef, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Narrowest width: a 'z' and five digits bring the column to six, just short of the terminator newline.
    set_width(WidthMin);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       w = 8'd8;
        1:       w = 8'd255;
        2:       w = 8'd0;
        3:       w = 8'($urandom_range(11, 254));
        4:       w = 8'd9;
        5:       w = 8'd7;
        6:       w = 8'($urandom_range(8, 16));
        default: w = 8'd10;
      endcase
      no_idle = (phase % 3 == 2);
      set_width(w);
      phase_items = 0;
      while (phase_items < 14) begin
        len = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) len = 4 * $urandom_range(1, 4);
        send_stream(len);
        phase_items += len;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/a85enc_pkg.sv
rtl/a85enc_front.sv
rtl/a85enc_fifo.sv
rtl/a85enc_conv.sv
rtl/a85enc_emit.sv
rtl/ascii85_encoder_line_wrap_unit.sv
verif/a85_stream_checker.sv
verif/tb.sv
